FILE: hdl/fbb_pkg.sv
// Package for the framebuffer blitter: command codes, field widths and defaults.
// Used by fbb_engine and framebuffer_blitter_with_damage.
`timescale 1ns / 1ps
`default_nettype none
package fbb_pkg;
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;
    localparam int PIXEL_BITS_DEF = 32;

    localparam logic [2:0] MODE_FILL   = 3'd0;
    localparam logic [2:0] MODE_PUT    = 3'd1;
    localparam logic [2:0] MODE_GET    = 3'd2;
    localparam logic [2:0] MODE_SCROLL = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;
    localparam logic [2:0] MODE_DAMAGE = 3'd5;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [15:0] scroll_rows;
        logic [31:0] color;
    } cmd_t;

    typedef struct packed {
        logic [31:0] read_pixel;
        logic        damage_valid;
        logic [6:0]  damage_x;
        logic [6:0]  damage_y;
        logic [7:0]  damage_width;
        logic [7:0]  damage_height;
    } res_t;
endpackage
`default_nettype wire

FILE: hdl/fbb_engine.sv
// Command sequencer with frame memory, one shared address unit and damage tracking.
// Depends on fbb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbb_engine #(
    parameter int MAX_WIDTH  = fbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbb_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = fbb_pkg::PIXEL_BITS_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cmd_valid,
    output logic         cmd_ready,
    input  fbb_pkg::cmd_t cmd,
    input  wire  [7:0]   surf_w,
    input  wire  [7:0]   surf_h,
    output logic         res_valid,
    input  wire          res_ready,
    output fbb_pkg::res_t res
);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_RDWT  = 3'd3;
    localparam logic [2:0] ST_GROW  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_GETWT = 3'd6;

    logic [2:0] state_reg, state_next;
    fbb_pkg::cmd_t cmd_reg;
    logic [XW-1:0] ew;
    logic [YW-1:0] eh;
    logic [XW-1:0] bx_reg, cw_reg, i_reg;
    logic [YW-1:0] by_reg, ch_reg, j_reg, rows_reg;
    logic [YW-1:0] n_c;
    logic [DW-1:0] row_base_reg;   // y * width of current row
    logic [DW-1:0] src_off_reg;    // n * width
    logic          copy_phase_reg;
    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] rd_reg;
    logic          dflag_reg;
    logic [XW-1:0] dl_reg, dsx_reg;
    logic [YW-1:0] dt_reg, dsy_reg;
    fbb_pkg::res_t res_reg;
    logic          res_valid_reg;

    // saturate surface size
    assign ew = (surf_w > 8'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(surf_w);
    assign eh = (surf_h > 8'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(surf_h);

    // clip of the captured command
    logic          origin_ok;
    logic [16:0]   room_x, room_y;
    logic [XW-1:0] cw_c;
    logic [YW-1:0] ch_c;
    logic [15:0]   rw_c, rh_c;
    always_comb begin
        origin_ok = (ew != '0) && (eh != '0) && (cmd_reg.pos_x < 16'(ew))
                    && (cmd_reg.pos_y < 16'(eh));
        rw_c = cmd_reg.rect_width;
        rh_c = cmd_reg.rect_height;
        if (cmd_reg.mode == fbb_pkg::MODE_PUT) begin
            rw_c = 16'd1;
            rh_c = 16'd1;
        end
        room_x = 17'(ew) - 17'(cmd_reg.pos_x);
        room_y = 17'(eh) - 17'(cmd_reg.pos_y);
        cw_c = (17'(rw_c) < room_x) ? XW'(rw_c) : XW'(room_x);
        ch_c = (17'(rh_c) < room_y) ? YW'(rh_c) : YW'(room_y);
        n_c  = (cmd_reg.scroll_rows < 16'(ch_c)) ? YW'(cmd_reg.scroll_rows) : ch_c;
    end

    // current pixel address from the walk counters
    logic [DW-1:0] addr_w;
    logic [AW-1:0] wa, ra;
    assign addr_w = row_base_reg + DW'(bx_reg) + DW'(i_reg);
    assign wa = AW'(addr_w);
    assign ra = AW'(addr_w + src_off_reg);

    logic mem_we, mem_re;
    logic [PIXEL_BITS-1:0] wdata;
    logic [AW-1:0] raddr;
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        raddr  = ra;
        wdata  = cmd_reg.color[PIXEL_BITS-1:0];
        if (state_reg == ST_WALK) begin
            if (copy_phase_reg) mem_re = 1'b1;
            else mem_we = 1'b1;
        end
        if (state_reg == ST_RDWT) begin
            mem_we = 1'b1;
            wdata = rd_reg;
        end
        if (state_reg == ST_PREP) begin
            mem_re = 1'b1;
            raddr = AW'(DW'(cmd_reg.pos_y[YW-1:0]) * DW'(ew) + DW'(cmd_reg.pos_x[XW-1:0]));
        end
    end

    // frame memory
    always_ff @(posedge aclk) begin
        if (mem_we) mem[wa] <= wdata;
        if (mem_re) rd_reg <= mem[raddr];
    end

    logic last_i, last_j;
    assign last_i = (i_reg == cw_reg - XW'(1));
    assign last_j = (j_reg == ch_reg - YW'(1));

    // damage grow
    logic [XW:0] r1, r2;
    logic [YW:0] b1, b2;
    logic [XW-1:0] gl;
    logic [YW-1:0] gt;
    always_comb begin
        gl = (dl_reg < bx_reg) ? dl_reg : bx_reg;
        gt = (dt_reg < by_reg) ? dt_reg : by_reg;
        r1 = (XW+1)'(dl_reg) + (XW+1)'(dsx_reg);
        r2 = (XW+1)'(bx_reg) + (XW+1)'(cw_reg);
        b1 = (YW+1)'(dt_reg) + (YW+1)'(dsy_reg);
        b2 = (YW+1)'(by_reg) + (YW+1)'(ch_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dflag_reg <= 1'b0;
            dl_reg <= '0; dt_reg <= '0; dsx_reg <= '0; dsy_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && res_ready && state_reg != ST_OUT) res_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg <= cmd;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    i_reg <= '0;
                    j_reg <= '0;
                    state_reg <= ST_OUT;
                    unique case (cmd_reg.mode) inside
                        fbb_pkg::MODE_FILL, fbb_pkg::MODE_PUT, fbb_pkg::MODE_CLEAR: begin
                            res_reg <= '0;
                            bx_reg <= (cmd_reg.mode == fbb_pkg::MODE_CLEAR) ? '0 : XW'(cmd_reg.pos_x);
                            by_reg <= (cmd_reg.mode == fbb_pkg::MODE_CLEAR) ? '0 : YW'(cmd_reg.pos_y);
                            cw_reg <= (cmd_reg.mode == fbb_pkg::MODE_CLEAR) ? ew : cw_c;
                            ch_reg <= (cmd_reg.mode == fbb_pkg::MODE_CLEAR) ? eh : ch_c;
                            row_base_reg <= (cmd_reg.mode == fbb_pkg::MODE_CLEAR) ? '0 :
                                DW'(cmd_reg.pos_y[YW-1:0]) * DW'(ew);
                            rows_reg <= '0;
                            copy_phase_reg <= 1'b0;
                            src_off_reg <= '0;
                            if ((cmd_reg.mode == fbb_pkg::MODE_CLEAR && ew != '0 && eh != '0)
                                || (cmd_reg.mode != fbb_pkg::MODE_CLEAR && origin_ok
                                    && cw_c != '0 && ch_c != '0))
                                state_reg <= ST_WALK;
                        end
                        fbb_pkg::MODE_SCROLL: begin
                            res_reg <= '0;
                            bx_reg <= XW'(cmd_reg.pos_x);
                            by_reg <= YW'(cmd_reg.pos_y);
                            cw_reg <= cw_c;
                            ch_reg <= ch_c;
                            row_base_reg <= DW'(cmd_reg.pos_y[YW-1:0]) * DW'(ew);
                            rows_reg <= ch_c - n_c;
                            copy_phase_reg <= (ch_c != n_c);
                            src_off_reg <= DW'(n_c) * DW'(ew);
                            if (origin_ok && cw_c != '0 && ch_c != '0
                                && cmd_reg.scroll_rows != 16'd0)
                                state_reg <= ST_WALK;
                        end
                        fbb_pkg::MODE_GET: begin
                            res_reg <= '0;
                            if (origin_ok) state_reg <= ST_GETWT;
                        end
                        fbb_pkg::MODE_DAMAGE: begin
                            if (ew != '0 && eh != '0 && dflag_reg) begin
                                res_reg <= {32'd0, 1'b1, 7'(dl_reg), 7'(dt_reg),
                                            8'(dsx_reg), 8'(dsy_reg)};
                                dflag_reg <= 1'b0;
                                dl_reg <= '0; dt_reg <= '0; dsx_reg <= '0; dsy_reg <= '0;
                            end else begin
                                res_reg <= '0;
                            end
                        end
                        default: res_reg <= '0;
                    endcase
                end
                ST_GETWT: begin
                    res_reg.read_pixel <= 32'(rd_reg);
                    state_reg <= ST_OUT;
                end
                ST_WALK: begin
                    if (copy_phase_reg) state_reg <= ST_RDWT;
                    else begin
                        // advance fill walk
                        if (last_i) begin
                            i_reg <= '0;
                            row_base_reg <= row_base_reg + DW'(ew);
                            if (last_j) state_reg <= ST_GROW;
                            else j_reg <= j_reg + YW'(1);
                        end else i_reg <= i_reg + XW'(1);
                    end
                end
                ST_RDWT: begin
                    state_reg <= ST_WALK;
                    if (last_i) begin
                        i_reg <= '0;
                        row_base_reg <= row_base_reg + DW'(ew);
                        j_reg <= j_reg + YW'(1);
                        if (j_reg == rows_reg - YW'(1)) copy_phase_reg <= 1'b0;
                    end else i_reg <= i_reg + XW'(1);
                end
                ST_GROW: begin
                    dflag_reg <= 1'b1;
                    if (!dflag_reg) begin
                        dl_reg <= bx_reg; dt_reg <= by_reg;
                        dsx_reg <= cw_reg; dsy_reg <= ch_reg;
                    end else begin
                        dl_reg <= gl; dt_reg <= gt;
                        dsx_reg <= XW'(((r1 > r2) ? r1 : r2) - (XW+1)'(gl));
                        dsy_reg <= YW'(((b1 > b2) ? b1 : b2) - (YW+1)'(gt));
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!res_valid_reg || res_ready) begin
                        res_valid_reg <= 1'b1;
                        res <= res_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE) && aresetn;
    assign res_valid = res_valid_reg;
endmodule
`default_nettype wire

FILE: hdl/framebuffer_blitter_with_damage.sv
// Top level of the framebuffer blitter: stream ports, packing, size registers.
// Depends on fbb_pkg and fbb_engine.
//
//  channel  direction  contents
//  s_axis   in         command transaction: mode, position, size, scroll, colour
//  m_axis   out        one result transaction per command
//  cfg      in         surface width (index 0) and height (index 1)
//
// A command passes the idle, prepare and output states. Fill, put and clear
// also walk the clipped rectangle writing each pixel, and a scroll reads and
// then writes each copied pixel (one memory read port and one write port,
// shared by the single address unit). Get pixel adds a memory read wait.
// Reset is synchronous; the frame memory is not cleared. A stalled result
// holds the sequencer until taken.
`timescale 1ns / 1ps
`default_nettype none
module framebuffer_blitter_with_damage #(
    parameter int MAX_WIDTH  = fbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbb_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = fbb_pkg::PIXEL_BITS_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // mode[2:0], pos_x, pos_y, rect_width, rect_height, scroll_rows, color, pad
    input  wire  [119:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // read_pixel[31:0], damage_valid, damage_x, damage_y, damage_width,
    // damage_height, pad
    output logic [63:0]  m_tdata,
    input  wire          cfg_we,
    input  wire          cfg_index,
    input  wire  [7:0]   cfg_data
);
    fbb_pkg::cmd_t cmd;
    fbb_pkg::res_t res;
    logic [7:0] sw_reg, sh_reg;

    // hold the surface size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= 8'd128;
            sh_reg <= 8'd128;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fbb_pkg::CFG_WIDTH:  sw_reg <= cfg_data;
                fbb_pkg::CFG_HEIGHT: sh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cmd.mode        = s_tdata[2:0];
    assign cmd.pos_x       = s_tdata[18:3];
    assign cmd.pos_y       = s_tdata[34:19];
    assign cmd.rect_width  = s_tdata[50:35];
    assign cmd.rect_height = s_tdata[66:51];
    assign cmd.scroll_rows = s_tdata[82:67];
    assign cmd.color       = s_tdata[114:83];

    fbb_engine #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(s_tvalid),
        .cmd_ready(s_tready),
        .cmd      (cmd),
        .surf_w   (sw_reg),
        .surf_h   (sh_reg),
        .res_valid(m_tvalid),
        .res_ready(m_tready),
        .res      (res)
    );

    assign m_tdata = {1'b0, res.damage_height, res.damage_width, res.damage_y,
                      res.damage_x, res.damage_valid, res.read_pixel};
endmodule
`default_nettype wire

FILE: tb/framebuffer_blitter_with_damage_tb.sv
// Self-checking testbench for framebuffer_blitter_with_damage: stream command and result
// channels, size registers, shadow frame store and damage tracker. Depends on fbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Shadow model of the blitter plus the queue of results still owed by the block
class blit_scoreboard;
    logic [31:0] pixels [16384];
    bit          written [16384];
    bit          dirty;
    int          d_left, d_top, d_span_x, d_span_y;
    int          width_reg, height_reg;
    fbb_pkg::res_t owed [$];
    int          mismatches;

    function new();
        dirty = 0; d_left = 0; d_top = 0; d_span_x = 0; d_span_y = 0;
        width_reg = 128; height_reg = 128; mismatches = 0;
        foreach (written[i]) written[i] = 0;
    endfunction

    function int eff_w();
        return (width_reg > 128) ? 128 : width_reg;
    endfunction

    function int eff_h();
        return (height_reg > 128) ? 128 : height_reg;
    endfunction

    function bit is_readable(int x, int y);
        return written[y * eff_w() + x];
    endfunction

    function void grow(int x, int y, int w, int h);
        int r, b;
        if (!dirty) begin
            d_left = x; d_top = y; d_span_x = w; d_span_y = h; dirty = 1;
            return;
        end
        r = (d_left + d_span_x > x + w) ? d_left + d_span_x : x + w;
        b = (d_top + d_span_y > y + h) ? d_top + d_span_y : y + h;
        if (x < d_left) d_left = x;
        if (y < d_top) d_top = y;
        d_span_x = r - d_left;
        d_span_y = b - d_top;
    endfunction

    // Clip to the surface; zero when the command does nothing
    function bit clip(int x, int y, inout int w, inout int h);
        if (eff_w() == 0 || eff_h() == 0 || x >= eff_w() || y >= eff_h())
            return 0;
        if (w > eff_w() - x) w = eff_w() - x;
        if (h > eff_h() - y) h = eff_h() - y;
        return (w != 0 && h != 0);
    endfunction

    function void fill_rect(int x, int y, int w, int h, logic [31:0] c);
        int a;
        if (!clip(x, y, w, h))
            return;
        for (int j = 0; j < h; j++)
            for (int i = 0; i < w; i++) begin
                a = (y + j) * eff_w() + x + i;
                pixels[a] = c;
                written[a] = 1;
            end
        grow(x, y, w, h);
    endfunction

    function void scroll(int x, int y, int w, int h, int n, logic [31:0] c);
        int rows, dst, src;
        if (n == 0 || !clip(x, y, w, h))
            return;
        if (n >= h) begin
            fill_rect(x, y, w, h, c);
            return;
        end
        rows = h - n;
        for (int j = 0; j < rows; j++)
            for (int i = 0; i < w; i++) begin
                dst = (y + j) * eff_w() + x + i;
                src = (y + j + n) * eff_w() + x + i;
                pixels[dst] = pixels[src];
                written[dst] = written[src];
            end
        fill_rect(x, y + rows, w, n, c);
        grow(x, y, w, h);
    endfunction

    // Note an accepted command transaction and queue the result it owes
    function void note_command(fbb_pkg::cmd_t cmd);
        fbb_pkg::res_t res;
        int x, y;
        res = '0;
        x = cmd.pos_x;
        y = cmd.pos_y;
        case (cmd.mode)
            fbb_pkg::MODE_FILL:
                fill_rect(x, y, cmd.rect_width, cmd.rect_height, cmd.color);
            fbb_pkg::MODE_PUT:
                fill_rect(x, y, 1, 1, cmd.color);
            fbb_pkg::MODE_GET:
                if (eff_w() != 0 && eff_h() != 0 && x < eff_w() && y < eff_h())
                    res.read_pixel = pixels[y * eff_w() + x];
            fbb_pkg::MODE_SCROLL:
                scroll(x, y, cmd.rect_width, cmd.rect_height, cmd.scroll_rows, cmd.color);
            fbb_pkg::MODE_CLEAR:
                fill_rect(0, 0, eff_w(), eff_h(), cmd.color);
            fbb_pkg::MODE_DAMAGE:
                if (eff_w() != 0 && eff_h() != 0 && dirty) begin
                    res.damage_valid  = 1'b1;
                    res.damage_x      = d_left[6:0];
                    res.damage_y      = d_top[6:0];
                    res.damage_width  = d_span_x[7:0];
                    res.damage_height = d_span_y[7:0];
                    dirty = 0; d_left = 0; d_top = 0; d_span_x = 0; d_span_y = 0;
                end
            default: ;
        endcase
        owed.push_back(res);
    endfunction

    function void report(string field, longint unsigned exp_v, longint unsigned act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", field, exp_v, act_v);
    endfunction

    // Check one result transaction against the oldest owed result
    function void check_result(fbb_pkg::res_t got);
        fbb_pkg::res_t want;
        if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result transaction with nothing owed: %h", got);
            return;
        end
        want = owed.pop_front();
        if (got.read_pixel !== want.read_pixel)
            report("read_pixel", want.read_pixel, got.read_pixel);
        if (got.damage_valid !== want.damage_valid)
            report("damage_valid", want.damage_valid, got.damage_valid);
        if (got.damage_x !== want.damage_x)
            report("damage_x", want.damage_x, got.damage_x);
        if (got.damage_y !== want.damage_y)
            report("damage_y", want.damage_y, got.damage_y);
        if (got.damage_width !== want.damage_width)
            report("damage_width", want.damage_width, got.damage_width);
        if (got.damage_height !== want.damage_height)
            report("damage_height", want.damage_height, got.damage_height);
    endfunction
endclass

module framebuffer_blitter_with_damage_tb;
    localparam int WATCHDOG_LIMIT = 200000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         cfg_we;
    logic         cfg_index;
    logic [7:0]   cfg_data;

    blit_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    framebuffer_blitter_with_damage dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Randomly stall the result channel
    always @(negedge aclk)
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);

    // Check result transactions and run the watchdog
    always @(posedge aclk) begin
        fbb_pkg::res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.read_pixel    = m_tdata[31:0];
            got.damage_valid  = m_tdata[32];
            got.damage_x      = m_tdata[39:33];
            got.damage_y      = m_tdata[46:40];
            got.damage_width  = m_tdata[54:47];
            got.damage_height = m_tdata[62:55];
            sb.check_result(got);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[framebuffer_blitter_with_damage] ERROR");
            $finish;
        end
    end

    // Send one command transaction, with a random gap before it
    task automatic send_command(input fbb_pkg::cmd_t cmd);
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, cmd.color, cmd.scroll_rows, cmd.rect_height, cmd.rect_width,
                    cmd.pos_y, cmd.pos_x, cmd.mode};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic make_command(output fbb_pkg::cmd_t cmd, input logic [2:0] mode,
                                input int x, input int y, input int w, input int h,
                                input int n, input logic [31:0] c);
        cmd.mode = mode; cmd.pos_x = 16'(x); cmd.pos_y = 16'(y); cmd.rect_width = 16'(w);
        cmd.rect_height = 16'(h); cmd.scroll_rows = 16'(n); cmd.color = c;
    endtask

    task automatic issue(input logic [2:0] mode, input int x, input int y, input int w,
                         input int h, input int n, input logic [31:0] c);
        fbb_pkg::cmd_t cmd;
        make_command(cmd, mode, x, y, w, h, n, c);
        send_command(cmd);
    endtask

    // Wait until every owed result has arrived
    task automatic drain();
        while (sb.owed.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_size(input logic index, input int value);
        cfg_we = 1'b1; cfg_index = index; cfg_data = value[7:0];
        @(negedge aclk);
        cfg_we = 1'b0;
        if (index == fbb_pkg::CFG_WIDTH) sb.width_reg = value & 8'hFF;
        else sb.height_reg = value & 8'hFF;
    endtask

    // Random coordinate: mostly inside the surface, sometimes anywhere
    function automatic int pick_coord(int limit);
        if (limit == 0 || $urandom_range(0, 99) < 8)
            return $urandom_range(0, 65535);
        return $urandom_range(0, limit - 1);
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return $urandom_range(0, 65535);
        if (r < 8) return $urandom_range(0, 40);
        return $urandom_range(0, 8);
    endfunction

    task automatic random_command();
        fbb_pkg::cmd_t cmd;
        int r, w, h;
        logic [2:0] mode;
        r = $urandom_range(0, 99);
        w = sb.eff_w();
        h = sb.eff_h();
        if (r < 20) mode = fbb_pkg::MODE_FILL;
        else if (r < 42) mode = fbb_pkg::MODE_PUT;
        else if (r < 68) mode = fbb_pkg::MODE_GET;
        else if (r < 83) mode = fbb_pkg::MODE_SCROLL;
        else if (r < 84) mode = fbb_pkg::MODE_CLEAR;
        else if (r < 97) mode = fbb_pkg::MODE_DAMAGE;
        else mode = 3'($urandom_range(6, 7));
        make_command(cmd, mode, pick_coord(w), pick_coord(h), pick_size(), pick_size(),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 10),
                     $urandom());
        // Never read a pixel that was never written; push such a read off the surface
        if (mode == fbb_pkg::MODE_GET && cmd.pos_x < w && cmd.pos_y < h
                && !sb.is_readable(cmd.pos_x, cmd.pos_y))
            cmd.pos_x = 16'hFFFF;
        send_command(cmd);
    endtask

    initial begin
        int widths [6]  = '{128, 1, 0, 255, 37, 128};
        int heights [6] = '{128, 1, 17, 200, 5, 128};
        sb = new();
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        cfg_we = 1'b0; cfg_index = fbb_pkg::CFG_WIDTH; cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; quiet_cycles = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: extremes, every mode and the corner cases
        issue(fbb_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 32'h0);
        issue(fbb_pkg::MODE_PUT, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        issue(fbb_pkg::MODE_PUT, 127, 127, 0, 0, 0, 32'hA5A5_5A5A);
        issue(fbb_pkg::MODE_GET, 0, 0, 0, 0, 0, 32'h0);
        issue(fbb_pkg::MODE_GET, 127, 127, 0, 0, 0, 32'h0);
        issue(fbb_pkg::MODE_DAMAGE, 0, 0, 0, 0, 0, 32'h0);
        issue(fbb_pkg::MODE_DAMAGE, 0, 0, 0, 0, 0, 32'h0);
        issue(fbb_pkg::MODE_FILL, 120, 122, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h1234_5678);
        issue(fbb_pkg::MODE_FILL, 10, 10, 0, 5, 0, 32'hDEAD_BEEF);
        issue(fbb_pkg::MODE_FILL, 128, 3, 4, 4, 0, 32'hDEAD_BEEF);
        issue(fbb_pkg::MODE_PUT, 3, 16'hFFFF, 0, 0, 0, 32'h1);
        issue(fbb_pkg::MODE_GET, 16'hFFFF, 16'hFFFF, 0, 0, 0, 32'h0);
        issue(fbb_pkg::MODE_DAMAGE, 0, 0, 0, 0, 0, 32'h0);
        issue(fbb_pkg::MODE_FILL, 4, 4, 6, 6, 0, 32'h0000_00FF);
        issue(fbb_pkg::MODE_SCROLL, 2, 2, 8, 8, 0, 32'h5555_5555);
        issue(fbb_pkg::MODE_SCROLL, 2, 2, 8, 8, 3, 32'hAAAA_AAAA);
        issue(fbb_pkg::MODE_SCROLL, 20, 20, 4, 4, 16'hFFFF, 32'h7777_7777);
        issue(fbb_pkg::MODE_GET, 5, 2, 0, 0, 0, 32'h0);
        issue(fbb_pkg::MODE_GET, 5, 8, 0, 0, 0, 32'h0);
        issue(fbb_pkg::MODE_DAMAGE, 0, 0, 0, 0, 0, 32'h0);
        issue(3'd6, 1, 1, 1, 1, 1, 32'hFFFF_FFFF);
        issue(3'd7, 1, 1, 1, 1, 1, 32'hFFFF_FFFF);
        issue(fbb_pkg::MODE_PUT, 9, 9, 0, 0, 0, 32'h8000_0001);

        // Random phases over several surface sizes and idling patterns
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            write_size(fbb_pkg::CFG_WIDTH, widths[phase]);
            write_size(fbb_pkg::CFG_HEIGHT, heights[phase]);
            // A zero-sized surface ignores everything, damage included
            if (phase == 2) begin
                issue(fbb_pkg::MODE_DAMAGE, 0, 0, 0, 0, 0, 32'h0);
                issue(fbb_pkg::MODE_PUT, 0, 0, 0, 0, 0, 32'h1);
                issue(fbb_pkg::MODE_GET, 0, 0, 0, 0, 0, 32'h0);
            end
            for (int k = 0; k < 165; k++) begin
                case ((k / 20) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                    default: begin send_idle_pct = 31; recv_stall_pct = 31; end
                endcase
                // Hold the sender until the block has caught up
                if (k == 80)
                    while (sb.owed.size() != 0) @(negedge aclk);
                random_command();
            end
        end

        while (sb.owed.size() != 0)
            @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (sb.mismatches == 0)
            $display("[framebuffer_blitter_with_damage] OK");
        else
            $display("[framebuffer_blitter_with_damage] ERROR");
        $finish;
    end
endmodule

`default_nettype wire

FILE: sim.f
hdl/fbb_pkg.sv
hdl/fbb_engine.sv
hdl/framebuffer_blitter_with_damage.sv
tb/framebuffer_blitter_with_damage_tb.sv
